// ===== sv/aes_ctr_stream_cipher_core_assert.svh =====
// assertion macros for the aes ctr core
// no dependencies
`ifndef AES_CTR_STREAM_CIPHER_CORE_ASSERT_SVH
`define AES_CTR_STREAM_CIPHER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define ACS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ACS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/acs_pkg.sv =====
// shared types, constants and aes functions for the aes ctr core
// no dependencies
package acs_pkg;

  localparam logic [7:0] RconInit = 8'h01;
  localparam logic [3:0] RoundsAes128 = 4'd10;
  localparam logic [3:0] RoundsAes256 = 4'd14;
  localparam logic [4:0] FullBlock = 5'd16;
  localparam logic [0:0] StatusOk = 1'b0;
  localparam logic [0:0] StatusReject = 1'b1;
  localparam logic [0:0] CmdStart = 1'b1;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegKey0 = 3'd1;
  localparam logic [2:0] RegKey1 = 3'd2;
  localparam logic [2:0] RegKey2 = 3'd3;
  localparam logic [2:0] RegKey3 = 3'd4;

  typedef struct packed {
    logic [0:0]  command;
    logic [63:0] nonce_high;
    logic [63:0] nonce_low;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } acs_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  valid_bytes;
    logic [0:0]  status;
  } acs_out_t;

  typedef enum logic [1:0] {
    StIdle,
    StRound,
    StDone
  } acs_state_e;

  // round unit control from the sequencer
  typedef struct packed {
    logic       load;
    logic       step;
    logic       last;
    logic       aes256;
  } acs_ctrl_t;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SboxTab[w[31:24]], SboxTab[w[23:16]], SboxTab[w[15:8]], SboxTab[w[7:0]]};
  endfunction

endpackage

// ===== sv/aes_ctr_stream_cipher_core.sv =====
// aes-ctr core: the result goes valid once the last round of the item has run (aes-128 or aes-256)
// the first key add happens at the accept edge, then the shared round unit runs 10 or 14 rounds
// the result is held until it is taken and the next item comes the cycle after it is taken,
// so the core takes no new item before the result of the last one is taken
// a rejected item (zero byte count) answers in the cycle after it is accepted
// reset (rst_ni low, async) clears counter, key, mode and control state
`include "aes_ctr_stream_cipher_core_assert.svh"
module aes_ctr_stream_cipher_core import acs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  acs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output acs_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  acs_state_e   state_q, state_d;
  logic         mode_q;
  logic [63:0]  key_q [4];
  logic [127:0] ctr_q, ctr_d;
  logic [127:0] data_q;
  logic [4:0]   cnt_q;
  logic [3:0]   round_q, round_d;
  acs_out_t     out_q, out_d;
  acs_ctrl_t    ctrl;
  logic [127:0] ks, mask, blk;
  logic         accept, wr;
  logic [2:0]   reg_idx;
  logic [4:0]   cnt_sat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegMode: prdata = {63'h0, mode_q};
      RegKey0: prdata = key_q[0];
      RegKey1: prdata = key_q[1];
      RegKey2: prdata = key_q[2];
      RegKey3: prdata = key_q[3];
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
    end else if (wr) begin
      if (reg_idx == RegMode) mode_q <= pwdata[0];
      for (int i = 0; i < 4; i++) begin
        if (reg_idx == RegKey0 + 3'(i)) key_q[i] <= pwdata;
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign accept      = in_valid_i && in_ready_o;
  assign cnt_sat = (in_data_i.byte_count > FullBlock) ? FullBlock : in_data_i.byte_count;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mask[127-8*i -: 8] = (5'(i) < cnt_q) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    ctr_d   = ctr_q;
    round_d = round_q;
    out_d   = out_q;
    ctrl    = '{load: 1'b0, step: 1'b0, last: 1'b0, aes256: mode_q};
    blk     = (in_data_i.command == CmdStart) ?
              {in_data_i.nonce_high, in_data_i.nonce_low} : ctr_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_data_i.byte_count == 5'd0) begin
            out_d   = '{result_high: '0, result_low: '0, valid_bytes: '0,
                        status: StatusReject};
            state_d = StDone;
          end else begin
            ctrl.load = 1'b1;
            ctr_d     = blk;
            round_d   = 4'd1;
            state_d   = StRound;
          end
        end
      end
      StRound: begin
        ctrl.step = 1'b1;
        ctrl.last = (round_q == (mode_q ? RoundsAes256 : RoundsAes128));
        round_d   = round_q + 4'd1;
        if (ctrl.last) begin
          state_d = StDone;
          ctr_d   = ctr_q + 128'd1;
          out_d   = '{result_high: '0, result_low: '0, valid_bytes: cnt_q,
                      status: StatusOk};
        end
      end
      StDone: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  acs_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .key_i   ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .block_i (blk),
    .state_o (ks)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ctr_q   <= '0;
      round_q <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= {in_data_i.data_high, in_data_i.data_low};
      cnt_q  <= cnt_sat;
    end
    out_q <= out_d;
  end

  // keystream stays in the round unit while the result waits
  always_comb begin
    out_data_o = out_q;
    if (out_q.status == StatusOk) begin
      out_data_o.result_high = (data_q[127:64] ^ ks[127:64]) & mask[127:64];
      out_data_o.result_low  = (data_q[63:0] ^ ks[63:0]) & mask[63:0];
    end
  end

  `ACS_ASSERT_IMP(a_ready_only_idle, clk_i, rst_ni, in_ready_o, !out_valid_o, "ready with pending result")
  `ACS_ASSERT_NEXT(a_last_to_done, clk_i, rst_ni, ctrl.last, state_q == StDone, "last round did not finish")
  `ACS_ASSERT_IMP(a_round_bound, clk_i, rst_ni, state_q == StRound, round_q <= RoundsAes256 && round_q != 4'd0, "round count out of range")

endmodule

// ===== sv/acs_round.sv =====
// shared aes round unit with on-the-fly key expansion, one round per step
// depends on acs_pkg
module acs_round import acs_pkg::*; (
  input  logic         clk_i,
  input  acs_ctrl_t    ctrl_i,
  input  logic [255:0] key_i,
  input  logic [127:0] block_i,
  output logic [127:0] state_o
);

  logic [127:0] state_q, state_d;
  // sliding key window w[i..i+7]; for aes-256 the low half is the next round key
  logic [255:0] kwin_q, kwin_d;
  logic [7:0]   rcon_q, rcon_d;
  logic         phase_q, phase_d;   // aes-256: alternates rcon and plain sub steps

  logic [127:0] sb, sr, mc, rk;
  logic [7:0]   b [16];
  logic [7:0]   t [16];
  logic [31:0]  w0, w1, w2, w3, w4, w5, w6, w7, tw;
  logic [31:0]  n0, n1, n2, n3;
  logic         use_rcon;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      b[i] = SboxTab[state_q[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[c*4+i] = b[((c+i)&3)*4+i];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sr[127-8*i -: 8] = t[i];
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[127-32*c -: 8]  = a0 ^ al ^ xtime(a0 ^ a1);
      mc[119-32*c -: 8]  = a1 ^ al ^ xtime(a1 ^ a2);
      mc[111-32*c -: 8]  = a2 ^ al ^ xtime(a2 ^ a3);
      mc[103-32*c -: 8]  = a3 ^ al ^ xtime(a3 ^ a0);
    end
    sb = ctrl_i.last ? sr : mc;

    // next four key words
    {w0, w1, w2, w3, w4, w5, w6, w7} = kwin_q;
    use_rcon = !ctrl_i.aes256 || !phase_q;
    if (ctrl_i.aes256) begin
      tw = use_rcon ? (sub_word({w7[23:0], w7[31:24]}) ^ {rcon_q, 24'h0}) : sub_word(w7);
      n0 = w0 ^ tw;
    end else begin
      tw = sub_word({w3[23:0], w3[31:24]}) ^ {rcon_q, 24'h0};
      n0 = w0 ^ tw;
    end
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    rk = ctrl_i.aes256 ? {w4, w5, w6, w7} : {n0, n1, n2, n3};

    state_d = state_q;
    kwin_d  = kwin_q;
    rcon_d  = rcon_q;
    phase_d = phase_q;
    if (ctrl_i.load) begin
      state_d = block_i ^ key_i[255:128];
      kwin_d  = ctrl_i.aes256 ? key_i : {key_i[255:128], 128'h0};
      rcon_d  = RconInit;
      phase_d = 1'b0;
    end else if (ctrl_i.step) begin
      state_d = sb ^ rk;
      if (ctrl_i.aes256) begin
        kwin_d  = {w4, w5, w6, w7, n0, n1, n2, n3};
        phase_d = !phase_q;
        if (use_rcon) rcon_d = xtime(rcon_q);
      end else begin
        kwin_d = {n0, n1, n2, n3, 128'h0};
        rcon_d = xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    kwin_q  <= kwin_d;
    rcon_q  <= rcon_d;
    phase_q <= phase_d;
  end

  assign state_o = state_q;

endmodule
